// File: rtl/key_remap_table_defines.svh
// ----------------------------------------------------------------------------
// Key remap table assertion macros
// Shared concurrent assertion forms for the key remap table.
// ----------------------------------------------------------------------------
`ifndef KEY_REMAP_TABLE_DEFINES_SVH
`define KEY_REMAP_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/krt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key remap table package
// Sizes, operation and status codes, and the types shared by the modules.
// ----------------------------------------------------------------------------
package krt_pkg;

	localparam int ENTRIES  = 64;
	localparam int KEY_BITS = 16;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [1:0]          kind_t;
	typedef logic [1:0]          status_t;

	localparam kind_t KIND_LOOKUP = 2'd0;
	localparam kind_t KIND_SET    = 2'd1;
	localparam kind_t KIND_CLEAR  = 2'd2;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_REJECT = 2'd1;
	localparam status_t ST_FULL   = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	typedef struct packed {
		kind_t kind;
		key_t  src;
		key_t  dst;
	} req_t;

	typedef struct packed {
		key_t    target;
		logic    found;
		status_t status;
	} res_t;

	typedef struct packed {
		logic idle;
		logic done;
	} eng_stat_t;

endpackage

// File: rtl/key_remap_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key remap table
// Associative table of source to target key pairs with lookup, set and clear.
// ----------------------------------------------------------------------------
// The table holds up to ENTRIES source/target pairs in one memory and answers
// each item with exactly one result item. A lookup or a set walks the pairs in
// use, one per cycle, through the memory's single registered read port, and
// ends early when the source sits near the bottom of the table. A clear, a
// rejected set, any item on an empty table and the unused kind code go to the
// result without a scan. One item is worked on at a time; the next item is
// accepted as soon as the finished result has moved into the output register,
// even if the consumer has not yet taken it. The memory needs no clearing pass
// after reset: only entries below the fill count are ever read, and those have
// all been written. The invalid key register sits on its own write channel and
// should only be changed while the table is idle.
module key_remap_table import krt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	// Configuration write channel.
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  key_t    cfg_data,
	// Request channel.
	input  logic    in_valid,
	output logic    in_ready,
	input  kind_t   kind,
	input  key_t    source_key,
	input  key_t    new_target,
	// Result channel.
	output logic    out_valid,
	input  logic    out_ready,
	output key_t    target_key,
	output logic    found,
	output status_t status
);

`include "key_remap_table_defines.svh"

	key_t      invalid_key_q;
	logic      out_valid_q;
	res_t      out_q;
	eng_stat_t eng_stat;
	res_t      eng_res;
	req_t      req;
	logic      start;
	logic      res_ready;

	// The register is always writable; the user keeps writes to idle periods.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invalid_key_q <= '0;
		end else if (cfg_valid) begin
			invalid_key_q <= cfg_data;
		end
	end

	// An item is taken whenever the engine has nothing in hand.
	assign in_ready   = eng_stat.idle;
	assign start      = in_valid && in_ready;
	assign req.kind   = kind;
	assign req.src    = source_key;
	assign req.dst    = new_target;

	// The output register frees the engine as soon as a result lands in it.
	assign res_ready = !out_valid_q || out_ready;

	krt_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req         (req),
		.invalid_key (invalid_key_q),
		.res_ready   (res_ready),
		.stat        (eng_stat),
		.res         (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_stat.done && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_stat.done && res_ready) begin
			out_q <= eng_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign target_key = out_q.target;
	assign found      = out_q.found;
	assign status     = out_q.status;

	// Once an item is taken the engine must be busy with it in the next cycle.
	`KRT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready,
		"engine still idle after accepting an item")

	// A hit or an update is never reported together with an error status.
	`KRT_ASSERT_SAME(a_found_ok, clk, arst_n, out_valid && found, status == ST_OK,
		"found set with a non-ok status")

	// The engine can never be idle and holding a result at once.
	`KRT_ASSERT_SAME(a_stat_excl, clk, arst_n, eng_stat.done, !in_ready,
		"engine offers a result while accepting items")

endmodule

// File: rtl/krt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key remap table engine
// Pair memory, fill count and the sequencer that scans, updates and appends.
// ----------------------------------------------------------------------------
module krt_engine import krt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  req_t      req,
	input  key_t      invalid_key,
	input  logic      res_ready,
	output eng_stat_t stat,
	output res_t      res
);

	logic [2*KEY_BITS-1:0] mem_q [ENTRIES];
	logic [2*KEY_BITS-1:0] entry_s1;
	logic [IDX_W-1:0]      idx_s1, idx_d;

	state_t            state_q, state_d;
	req_t              op_q, op_d;
	res_t              res_q, res_d;
	logic [CNT_W-1:0]  used_q, used_d;
	logic [CNT_W-1:0]  ptr_q, ptr_d;

	logic                  rd_en, wr_en;
	logic [IDX_W-1:0]      rd_addr, wr_addr;
	logic [2*KEY_BITS-1:0] wr_data;
	logic                  hit, last, full;

	assign hit  = (entry_s1[2*KEY_BITS-1:KEY_BITS] == op_q.src);
	assign last = (CNT_W'(idx_s1) == used_q - CNT_W'(1));
	assign full = (used_q == CNT_W'(ENTRIES));

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		res_d   = res_q;
		used_d  = used_q;
		ptr_d   = ptr_q;
		idx_d   = idx_s1;
		rd_en   = 1'b0;
		rd_addr = ptr_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = {op_q.src, op_q.dst};
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d         = req;
					res_d.target = invalid_key;
					res_d.found  = 1'b0;
					res_d.status = ST_OK;
					state_d      = S_DONE;
					case (req.kind)
						KIND_LOOKUP, KIND_SET: begin
							if (req.kind == KIND_SET &&
							    (req.src == invalid_key || req.dst == invalid_key)) begin
								res_d.status = ST_REJECT;
							end else if (used_q != '0) begin
								rd_en   = 1'b1;
								rd_addr = '0;
								ptr_d   = CNT_W'(1);
								idx_d   = '0;
								state_d = S_SCAN;
							end else if (req.kind == KIND_SET) begin
								// Empty table: the pair goes straight into the first entry.
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = {req.src, req.dst};
								used_d  = CNT_W'(1);
							end
						end
						KIND_CLEAR: begin
							used_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				rd_en = (ptr_q < used_q);
				ptr_d = ptr_q + CNT_W'(1);
				idx_d = ptr_q[IDX_W-1:0];
				if (hit) begin
					state_d     = S_DONE;
					res_d.found = 1'b1;
					if (op_q.kind == KIND_LOOKUP) begin
						res_d.target = entry_s1[KEY_BITS-1:0];
					end else begin
						wr_en = 1'b1;
					end
				end else if (last) begin
					state_d = S_DONE;
					if (op_q.kind == KIND_SET) begin
						if (full) begin
							res_d.status = ST_FULL;
						end else begin
							wr_en   = 1'b1;
							wr_addr = used_q[IDX_W-1:0];
							used_d  = used_q + CNT_W'(1);
						end
					end
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			ptr_q   <= ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		res_q  <= res_d;
		idx_s1 <= idx_d;
	end

	// Pair memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			entry_s1 <= mem_q[rd_addr];
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign res       = res_q;

endmodule
